// ----- src/mecr_pkg.sv -----
`default_nettype none

package mecr_pkg;

    localparam int TS_W          = 40;
    localparam int SHOW_MASK_W   = 10;
    localparam int WINDOW_W      = 20;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 20;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic        req_type;
        logic [3:0]  status_nibble;
        logic [3:0]  chan;
        logic [6:0]  data_one;
        logic [6:0]  data_two;
        logic [11:0] sysex_length;
    } t_in_word;

    typedef struct packed {
        logic [4:0]  event_kind;
        logic [3:0]  event_channel;
        logic [13:0] event_number;
        logic [13:0] event_value;
        logic [39:0] time_stamp;
        logic        is_last;
    } t_out_word;

    typedef struct packed {
        t_out_word first_word;
        t_out_word second_word;
        logic      has_second;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_MASK   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_WINDOW = 1'b1;

    localparam logic [SHOW_MASK_W-1:0] SHOW_MASK_RESET   = 10'd639;
    localparam logic [WINDOW_W-1:0]    PAIR_WINDOW_RESET = 20'd4800;

    localparam int BIT_NOTE      = 0;
    localparam int BIT_KEYPRESS  = 1;
    localparam int BIT_CC        = 2;
    localparam int BIT_CCEXT     = 3;
    localparam int BIT_PROGRAM   = 4;
    localparam int BIT_CHANPRESS = 5;
    localparam int BIT_PITCH     = 6;
    localparam int BIT_SYSEX     = 7;
    localparam int BIT_CLOCK     = 8;
    localparam int BIT_SYSTEM    = 9;

    localparam logic [4:0] KIND_NOTEON    = 5'd0;
    localparam logic [4:0] KIND_NOTEOFF   = 5'd1;
    localparam logic [4:0] KIND_KEYPRESS  = 5'd2;
    localparam logic [4:0] KIND_CC        = 5'd3;
    localparam logic [4:0] KIND_PROG      = 5'd4;
    localparam logic [4:0] KIND_CHANPRESS = 5'd5;
    localparam logic [4:0] KIND_PITCH     = 5'd6;
    localparam logic [4:0] KIND_SYSEX     = 5'd7;
    localparam logic [4:0] KIND_SONGPTR   = 5'd8;
    localparam logic [4:0] KIND_SONGSEL   = 5'd9;
    localparam logic [4:0] KIND_CLOCK     = 5'd10;
    localparam logic [4:0] KIND_START     = 5'd11;
    localparam logic [4:0] KIND_CONT      = 5'd12;
    localparam logic [4:0] KIND_STOP      = 5'd13;
    localparam logic [4:0] KIND_RPNRESET  = 5'd14;
    localparam logic [4:0] KIND_RPNSEL    = 5'd15;
    localparam logic [4:0] KIND_NRPNSEL   = 5'd16;
    localparam logic [4:0] KIND_RPNDATA   = 5'd17;
    localparam logic [4:0] KIND_NRPNDATA  = 5'd18;
    localparam logic [4:0] KIND_CC14      = 5'd19;

    localparam logic [3:0] ST_NOTEOFF   = 4'h8;
    localparam logic [3:0] ST_NOTEON    = 4'h9;
    localparam logic [3:0] ST_KEYPRESS  = 4'hA;
    localparam logic [3:0] ST_CC        = 4'hB;
    localparam logic [3:0] ST_PROG      = 4'hC;
    localparam logic [3:0] ST_CHANPRESS = 4'hD;
    localparam logic [3:0] ST_PITCH     = 4'hE;
    localparam logic [3:0] ST_SYSTEM    = 4'hF;

    localparam logic [3:0] SYS_SYSEX   = 4'h0;
    localparam logic [3:0] SYS_SONGPTR = 4'h2;
    localparam logic [3:0] SYS_SONGSEL = 4'h3;
    localparam logic [3:0] SYS_CLOCK   = 4'h8;
    localparam logic [3:0] SYS_START   = 4'hA;
    localparam logic [3:0] SYS_CONT    = 4'hB;
    localparam logic [3:0] SYS_STOP    = 4'hC;

    localparam logic [6:0] CC_RPN_MSB   = 7'd101;
    localparam logic [6:0] CC_RPN_LSB   = 7'd100;
    localparam logic [6:0] CC_NRPN_MSB  = 7'd99;
    localparam logic [6:0] CC_NRPN_LSB  = 7'd98;
    localparam logic [6:0] CC_DATA_MSB  = 7'd6;
    localparam logic [6:0] CC_DATA_LSB  = 7'd38;
    localparam logic [6:0] CC_VAL_MAX   = 7'd127;
    localparam logic [6:0] RPN_SEL_MAX  = 7'd4;

    localparam logic [3:0]  RPN_NONE  = 4'hF;
    localparam logic [14:0] NRPN_NONE = 15'h7FFF;

endpackage

`default_nettype wire

// ----- src/midi_event_classifier_rpn_decoder.sv -----
// an accepted message enters the job queue, then its first word loads into the output register
// throughput: one input word per cycle while the queue has room; a cc pair event yields two
// output words, so a stream of them is limited by the output side
// rate is set by the single output register draining a four-entry job queue
// reset: synchronous, active low; clears counters, cc history, selections and the queue at once
// configuration returns to its defaults on reset
`default_nettype none

module midi_event_classifier_rpn_decoder #(
    parameter int NUM_CHANNELS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire mecr_pkg::t_in_word                i_in_word,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output mecr_pkg::t_out_word                    o_out_word,
    input  wire logic                              i_cfg_we,
    input  wire logic [mecr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [mecr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mecr_pkg::*;

    logic    push;
    logic    pop;
    t_job    job;
    t_job    head;
    t_q_stat q_stat;

    mecr_front #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_job       (job)
    );

    mecr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (job),
        .i_pop    (pop),
        .o_head   (head),
        .o_q_stat (q_stat)
    );

    mecr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_stat   (q_stat),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_word (o_out_word)
    );

endmodule

`default_nettype wire

// ----- src/mecr_front.sv -----
`default_nettype none

module mecr_front #(
    parameter int NUM_CHANNELS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire mecr_pkg::t_in_word                i_in_word,
    input  wire logic                              i_cfg_we,
    input  wire logic [mecr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [mecr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire mecr_pkg::t_q_stat                 i_q_stat,
    output logic                                   o_push,
    output mecr_pkg::t_job                         o_job
);
    import mecr_pkg::*;

    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [SHOW_MASK_W-1:0] r_show_mask;
    logic [WINDOW_W-1:0]    r_pair_window;
    logic [TS_W-1:0]        r_sample_count;
    logic                   r_prev_valid;
    logic [3:0]             r_prev_chan;
    logic [6:0]             r_prev_num;
    logic [6:0]             r_prev_val;
    logic [TS_W-1:0]        r_prev_time;
    logic [3:0]             r_rpn_sel  [NUM_CHANNELS];
    logic [14:0]            r_nrpn_sel [NUM_CHANNELS];

    logic            accept;
    logic [3:0]      st;
    logic [3:0]      ch;
    logic [6:0]      d1;
    logic [6:0]      d2;
    logic [TS_W-1:0] delta;
    logic            pair_base;
    logic            in_range;
    logic [3:0]      rsel;
    logic [14:0]     nsel;
    logic            has_a;
    logic            has_b;
    logic            ext;
    logic            data_entry;
    logic            sel_we;
    logic [3:0]      n_rpn;
    logic [14:0]     n_nrpn;
    t_out_word       word_a;
    t_out_word       word_b;

    assign o_stall = i_q_stat.full;
    assign accept  = i_valid && !i_q_stat.full;

    always_comb begin
        st = i_in_word.status_nibble;
        ch = i_in_word.chan;
        d1 = i_in_word.data_one;
        d2 = i_in_word.data_two;

        delta     = r_sample_count - r_prev_time;
        pair_base = r_prev_valid && (r_prev_chan == ch) && (delta < TS_W'(r_pair_window));
        in_range  = {1'b0, ch} < 5'(NUM_CHANNELS);
        rsel      = in_range ? r_rpn_sel[ch[CW-1:0]]  : RPN_NONE;
        nsel      = in_range ? r_nrpn_sel[ch[CW-1:0]] : NRPN_NONE;

        word_a            = '0;
        word_a.event_channel = ch;
        word_a.time_stamp = r_sample_count;
        word_b            = '0;
        word_b.event_channel = ch;
        word_b.time_stamp = r_sample_count;
        word_b.is_last    = 1'b1;
        has_a      = 1'b0;
        has_b      = 1'b0;
        ext        = 1'b0;
        data_entry = 1'b0;
        sel_we     = 1'b0;
        n_rpn      = RPN_NONE;
        n_nrpn     = NRPN_NONE;

        case (st)
            ST_NOTEON: begin
                has_a = r_show_mask[BIT_NOTE];
                word_a.event_kind   = KIND_NOTEON;
                word_a.event_number = {7'b0, d1};
                word_a.event_value  = {7'b0, d2};
            end
            ST_NOTEOFF: begin
                has_a = r_show_mask[BIT_NOTE];
                word_a.event_kind   = KIND_NOTEOFF;
                word_a.event_number = {7'b0, d1};
                word_a.event_value  = {7'b0, d2};
            end
            ST_KEYPRESS: begin
                has_a = r_show_mask[BIT_KEYPRESS];
                word_a.event_kind   = KIND_KEYPRESS;
                word_a.event_number = {7'b0, d1};
                word_a.event_value  = {7'b0, d2};
            end
            ST_CC: begin
                has_a = r_show_mask[BIT_CC];
                ext   = r_show_mask[BIT_CC] && r_show_mask[BIT_CCEXT];
                word_a.event_kind   = KIND_CC;
                word_a.event_number = {7'b0, d1};
                word_a.event_value  = {7'b0, d2};
            end
            ST_PROG: begin
                has_a = r_show_mask[BIT_PROGRAM];
                word_a.event_kind   = KIND_PROG;
                word_a.event_number = {7'b0, d1};
            end
            ST_CHANPRESS: begin
                has_a = r_show_mask[BIT_CHANPRESS];
                word_a.event_kind  = KIND_CHANPRESS;
                word_a.event_value = {7'b0, d1};
            end
            ST_PITCH: begin
                has_a = r_show_mask[BIT_PITCH];
                word_a.event_kind  = KIND_PITCH;
                word_a.event_value = {d2, d1};
            end
            ST_SYSTEM: begin
                word_a.event_channel = 4'd0;
                case (ch)
                    SYS_SYSEX: begin
                        has_a = r_show_mask[BIT_SYSEX];
                        word_a.event_kind  = KIND_SYSEX;
                        word_a.event_value = {2'b0, i_in_word.sysex_length};
                    end
                    SYS_SONGPTR: begin
                        has_a = r_show_mask[BIT_SYSTEM];
                        word_a.event_kind  = KIND_SONGPTR;
                        word_a.event_value = {d2, d1};
                    end
                    SYS_SONGSEL: begin
                        has_a = r_show_mask[BIT_SYSTEM];
                        word_a.event_kind  = KIND_SONGSEL;
                        word_a.event_value = {7'b0, d1};
                    end
                    SYS_CLOCK: begin
                        has_a = r_show_mask[BIT_CLOCK];
                        word_a.event_kind = KIND_CLOCK;
                    end
                    SYS_START: begin
                        has_a = r_show_mask[BIT_SYSTEM];
                        word_a.event_kind = KIND_START;
                    end
                    SYS_CONT: begin
                        has_a = r_show_mask[BIT_SYSTEM];
                        word_a.event_kind = KIND_CONT;
                    end
                    SYS_STOP: begin
                        has_a = r_show_mask[BIT_SYSTEM];
                        word_a.event_kind = KIND_STOP;
                    end
                    default: begin
                        has_a = 1'b0;
                    end
                endcase
            end
            default: begin
                has_a = 1'b0;
            end
        endcase

        if (ext) begin
            if (d1 == CC_RPN_LSB && pair_base && r_prev_num == CC_RPN_MSB) begin
                if (r_prev_val == CC_VAL_MAX && d2 == CC_VAL_MAX) begin
                    has_b  = 1'b1;
                    sel_we = 1'b1;
                    word_b.event_kind = KIND_RPNRESET;
                end else if (r_prev_val == 7'd0 && d2 <= RPN_SEL_MAX) begin
                    has_b  = 1'b1;
                    sel_we = 1'b1;
                    n_rpn  = d2[3:0];
                    word_b.event_kind   = KIND_RPNSEL;
                    word_b.event_number = {7'b0, d2};
                end
            end
            if (d1 == CC_NRPN_LSB && pair_base && r_prev_num == CC_NRPN_MSB) begin
                has_b  = 1'b1;
                sel_we = 1'b1;
                n_nrpn = {1'b0, r_prev_val, d2};
                word_b.event_kind   = KIND_NRPNSEL;
                word_b.event_number = {r_prev_val, d2};
            end
            if (d1 == CC_DATA_LSB && (rsel != RPN_NONE || nsel != NRPN_NONE)
                    && pair_base && r_prev_num == CC_DATA_MSB) begin
                has_b      = 1'b1;
                data_entry = 1'b1;
                word_b.event_value = {r_prev_val, d2};
                if (rsel != RPN_NONE) begin
                    word_b.event_kind   = KIND_RPNDATA;
                    word_b.event_number = {10'b0, rsel};
                end else begin
                    word_b.event_kind   = KIND_NRPNDATA;
                    word_b.event_number = nsel[13:0];
                end
            end
            if (d1[6:5] == 2'b01 && !data_entry && pair_base
                    && r_prev_num == {2'b00, d1[4:0]}) begin
                has_b = 1'b1;
                word_b.event_kind   = KIND_CC14;
                word_b.event_number = {9'b0, d1[4:0]};
                word_b.event_value  = {r_prev_val, d2};
            end
        end

        word_a.is_last = !has_b;
        o_job.first_word  = word_a;
        o_job.second_word = word_b;
        o_job.has_second  = has_b;
        o_push = accept && i_in_word.req_type && has_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_show_mask    <= SHOW_MASK_RESET;
            r_pair_window  <= PAIR_WINDOW_RESET;
            r_sample_count <= '0;
            r_prev_valid   <= 1'b0;
            r_prev_chan    <= '0;
            r_prev_num     <= '0;
            r_prev_val     <= '0;
            r_prev_time    <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_rpn_sel[i]  <= RPN_NONE;
                r_nrpn_sel[i] <= NRPN_NONE;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SHOW_MASK:   r_show_mask   <= i_cfg_data[SHOW_MASK_W-1:0];
                    CFG_PAIR_WINDOW: r_pair_window <= i_cfg_data[WINDOW_W-1:0];
                    default: begin
                        r_show_mask <= r_show_mask;
                    end
                endcase
            end
            if (accept) begin
                if (!i_in_word.req_type) begin
                    r_sample_count <= r_sample_count + TS_W'(1);
                end else if (ext) begin
                    r_prev_valid <= 1'b1;
                    r_prev_chan  <= ch;
                    r_prev_num   <= d1;
                    r_prev_val   <= d2;
                    r_prev_time  <= r_sample_count;
                    if (sel_we && in_range) begin
                        r_rpn_sel[ch[CW-1:0]]  <= n_rpn;
                        r_nrpn_sel[ch[CW-1:0]] <= n_nrpn;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/mecr_queue.sv -----
`default_nettype none

module mecr_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire mecr_pkg::t_job     i_job,
    input  wire logic               i_pop,
    output mecr_pkg::t_job          o_head,
    output mecr_pkg::t_q_stat       o_q_stat
);
    import mecr_pkg::*;

    t_job                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic [QUEUE_AW:0]   n_count;

    assign o_head         = r_slot[r_rd_ptr];
    assign o_q_stat.empty = (r_count == '0);
    assign o_q_stat.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + (QUEUE_AW+1)'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_q_stat.empty))
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_q_stat.full))
        else $error("push into full queue");

endmodule

`default_nettype wire

// ----- src/mecr_back.sv -----
`default_nettype none

module mecr_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire mecr_pkg::t_job     i_head,
    input  wire mecr_pkg::t_q_stat  i_q_stat,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output mecr_pkg::t_out_word     o_out_word
);
    import mecr_pkg::*;

    logic      r_valid;
    logic      n_valid;
    logic      r_phase;
    logic      n_phase;
    t_out_word r_word;
    t_out_word n_word;
    logic      load;

    assign load       = !r_valid || !i_stall;
    assign o_valid    = r_valid;
    assign o_out_word = r_word;

    always_comb begin
        n_valid = r_valid;
        n_phase = r_phase;
        n_word  = r_word;
        o_pop   = 1'b0;
        if (load) begin
            if (!i_q_stat.empty) begin
                n_valid = 1'b1;
                if (!r_phase) begin
                    n_word = i_head.first_word;
                    if (i_head.has_second) begin
                        n_phase = 1'b1;
                    end else begin
                        o_pop = 1'b1;
                    end
                end else begin
                    n_word  = i_head.second_word;
                    n_phase = 1'b0;
                    o_pop   = 1'b1;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import mecr_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam t_out_word NO_EVENT = '0;

    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word res;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    t_in_word              i_in_word = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_out_word             o_out_word;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // row-typed expectation travels with the word
    bit        row_typed = 1'b0;
    t_out_word row_res = '0;

    bit calm = 1'b0;
    int words_sent = 0;
    int words_in = 0;
    int errors = 0;
    int cycles = 0;

    // predictor state
    logic [9:0]  show_bits;
    logic [19:0] window;
    logic [39:0] samples;
    bit          last_cc_ok;
    logic [3:0]  last_cc_chan;
    logic [6:0]  last_cc_num;
    logic [6:0]  last_cc_val;
    logic [39:0] last_cc_time;
    logic [3:0]  rpn_sel [16];
    logic [14:0] nrpn_sel [16];

    t_out_word pending_events [$];
    t_out_word want;
    int        n0;
    t_row      script [$];

    midi_event_classifier_rpn_decoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_word   (i_in_word),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[midi_event_classifier_rpn_decoder] ERROR");
            $finish;
        end
    end

    function automatic void model_reset();
        show_bits = SHOW_MASK_RESET;
        window = PAIR_WINDOW_RESET;
        samples = '0;
        last_cc_ok = 1'b0;
        last_cc_chan = '0;
        last_cc_num = '0;
        last_cc_val = '0;
        last_cc_time = '0;
        for (int c = 0; c < 16; c++) begin
            rpn_sel[c] = RPN_NONE;
            nrpn_sel[c] = NRPN_NONE;
        end
    endfunction

    function automatic void add_event(logic [4:0] kind, logic [3:0] ch, logic [13:0] num,
                                      logic [13:0] val);
        t_out_word rec;
        rec.event_kind = kind;
        rec.event_channel = ch;
        rec.event_number = num;
        rec.event_value = val;
        rec.time_stamp = samples;
        rec.is_last = 1'b0;
        pending_events.insert(pending_events.size(), rec);
    endfunction

    function automatic bit pair_in_window(logic [3:0] ch, logic [6:0] want_num);
        logic [39:0] delta;
        delta = samples - last_cc_time;
        return last_cc_ok && last_cc_chan == ch && last_cc_num == want_num
               && delta < {20'd0, window};
    endfunction

    function automatic void decode_cc_pair(logic [3:0] ch, logic [6:0] cc, logic [6:0] v);
        logic [3:0]  rsel;
        logic [14:0] nsel;
        logic [13:0] joined;
        bit          data_hit;
        rsel = rpn_sel[ch];
        nsel = nrpn_sel[ch];
        joined = {last_cc_val, v};
        data_hit = 1'b0;
        if (cc == CC_RPN_LSB && pair_in_window(ch, CC_RPN_MSB)) begin
            if (last_cc_val == CC_VAL_MAX && v == CC_VAL_MAX) begin
                add_event(KIND_RPNRESET, ch, 0, 0);
                rpn_sel[ch] = RPN_NONE;
                nrpn_sel[ch] = NRPN_NONE;
            end else if (last_cc_val == 7'd0 && v <= RPN_SEL_MAX) begin
                add_event(KIND_RPNSEL, ch, v, 0);
                rpn_sel[ch] = v[3:0];
                nrpn_sel[ch] = NRPN_NONE;
            end
        end
        if (cc == CC_NRPN_LSB && pair_in_window(ch, CC_NRPN_MSB)) begin
            add_event(KIND_NRPNSEL, ch, joined, 0);
            nrpn_sel[ch] = {1'b0, joined};
            rpn_sel[ch] = RPN_NONE;
        end
        if (cc == CC_DATA_LSB && (rsel != RPN_NONE || nsel != NRPN_NONE)
            && pair_in_window(ch, CC_DATA_MSB)) begin
            if (rsel != RPN_NONE)
                add_event(KIND_RPNDATA, ch, rsel, joined);
            else
                add_event(KIND_NRPNDATA, ch, nsel[13:0], joined);
            data_hit = 1'b1;
        end
        if (cc >= 7'd32 && cc < 7'd64 && !data_hit && pair_in_window(ch, cc - 7'd32))
            add_event(KIND_CC14, ch, cc - 7'd32, joined);
        last_cc_ok = 1'b1;
        last_cc_chan = ch;
        last_cc_num = cc;
        last_cc_val = v;
        last_cc_time = samples;
    endfunction

    function automatic void classify_word(t_in_word w);
        int before_n;
        before_n = pending_events.size();
        if (!w.req_type) begin
            samples = samples + 40'd1;
            return;
        end
        case (w.status_nibble)
            ST_NOTEON:
                if (show_bits[BIT_NOTE]) add_event(KIND_NOTEON, w.chan, w.data_one, w.data_two);
            ST_NOTEOFF:
                if (show_bits[BIT_NOTE]) add_event(KIND_NOTEOFF, w.chan, w.data_one, w.data_two);
            ST_KEYPRESS:
                if (show_bits[BIT_KEYPRESS])
                    add_event(KIND_KEYPRESS, w.chan, w.data_one, w.data_two);
            ST_CC: begin
                if (show_bits[BIT_CC]) begin
                    add_event(KIND_CC, w.chan, w.data_one, w.data_two);
                    if (show_bits[BIT_CCEXT]) decode_cc_pair(w.chan, w.data_one, w.data_two);
                end
            end
            ST_PROG:
                if (show_bits[BIT_PROGRAM]) add_event(KIND_PROG, w.chan, w.data_one, 0);
            ST_CHANPRESS:
                if (show_bits[BIT_CHANPRESS]) add_event(KIND_CHANPRESS, w.chan, 0, w.data_one);
            ST_PITCH:
                if (show_bits[BIT_PITCH])
                    add_event(KIND_PITCH, w.chan, 0, {w.data_two, w.data_one});
            ST_SYSTEM: begin
                case (w.chan)
                    SYS_SYSEX:
                        if (show_bits[BIT_SYSEX])
                            add_event(KIND_SYSEX, 0, 0, {2'b00, w.sysex_length});
                    SYS_SONGPTR:
                        if (show_bits[BIT_SYSTEM])
                            add_event(KIND_SONGPTR, 0, 0, {w.data_two, w.data_one});
                    SYS_SONGSEL:
                        if (show_bits[BIT_SYSTEM]) add_event(KIND_SONGSEL, 0, 0, w.data_one);
                    SYS_CLOCK:
                        if (show_bits[BIT_CLOCK]) add_event(KIND_CLOCK, 0, 0, 0);
                    SYS_START:
                        if (show_bits[BIT_SYSTEM]) add_event(KIND_START, 0, 0, 0);
                    SYS_CONT:
                        if (show_bits[BIT_SYSTEM]) add_event(KIND_CONT, 0, 0, 0);
                    SYS_STOP:
                        if (show_bits[BIT_SYSTEM]) add_event(KIND_STOP, 0, 0, 0);
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (pending_events.size() > before_n)
            pending_events[pending_events.size() - 1].is_last = 1'b1;
    endfunction

    task automatic flag(input string what, input t_out_word exp_w, input t_out_word got_w);
        if (errors < 10) begin
            $display("%s: exp kind %0d ch %0d num %0d val %0d ts %0d last %0d",
                     what, exp_w.event_kind, exp_w.event_channel, exp_w.event_number,
                     exp_w.event_value, exp_w.time_stamp, exp_w.is_last);
            $display("    got kind %0d ch %0d num %0d val %0d ts %0d last %0d",
                     got_w.event_kind, got_w.event_channel, got_w.event_number,
                     got_w.event_value, got_w.time_stamp, got_w.is_last);
        end
        errors++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            model_reset();
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_events.size() == 0) begin
                    flag("unexpected word", NO_EVENT, o_out_word);
                end else begin
                    want = pending_events[0];
                    pending_events.delete(0);
                    if (want.event_kind !== o_out_word.event_kind
                        || want.event_channel !== o_out_word.event_channel
                        || want.event_number !== o_out_word.event_number
                        || want.event_value !== o_out_word.event_value
                        || want.time_stamp !== o_out_word.time_stamp
                        || want.is_last !== o_out_word.is_last)
                        flag("mismatch", want, o_out_word);
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_SHOW_MASK)
                    show_bits = i_cfg_data[SHOW_MASK_W-1:0];
                else if (i_cfg_index == CFG_PAIR_WINDOW)
                    window = i_cfg_data[WINDOW_W-1:0];
            end
            if (i_valid && !o_stall) begin
                words_in++;
                n0 = pending_events.size();
                classify_word(i_in_word);
                if (row_typed) begin
                    while (pending_events.size() > n0)
                        pending_events.delete(pending_events.size() - 1);
                    pending_events.insert(pending_events.size(), row_res);
                end
            end
        end
    end

    function automatic t_in_word midi_word(logic [3:0] st, logic [3:0] ch, logic [6:0] d1,
                                           logic [6:0] d2, logic [11:0] len);
        t_in_word w;
        w.req_type = 1'b1;
        w.status_nibble = st;
        w.chan = ch;
        w.data_one = d1;
        w.data_two = d2;
        w.sysex_length = len;
        return w;
    endfunction

    function automatic t_in_word raw_word(input bit as_tick);
        logic [63:0] r;
        t_in_word    w;
        r = {$urandom, $urandom};
        w = r[$bits(t_in_word)-1:0];
        if (as_tick) w.req_type = 1'b0;
        return w;
    endfunction

    function automatic t_out_word event_of(logic [4:0] kind, logic [3:0] ch, logic [13:0] num,
                                           logic [13:0] val);
        t_out_word rec;
        rec.event_kind = kind;
        rec.event_channel = ch;
        rec.event_number = num;
        rec.event_value = val;
        rec.time_stamp = '0;
        rec.is_last = 1'b1;
        return rec;
    endfunction

    task automatic send_word(input t_in_word w, input bit typed, input t_out_word res);
        int gap;
        gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 13) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_in_word <= w;
        row_typed <= typed;
        row_res <= res;
        words_sent++;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_pair(input logic [3:0] ch, input logic [6:0] n1, input logic [6:0] v1,
                             input logic [6:0] n2, input logic [6:0] v2, input int gap_max);
        int ticks;
        send_word(midi_word(ST_CC, ch, n1, v1, 12'd0), 1'b0, NO_EVENT);
        ticks = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, gap_max);
        repeat (ticks) send_word(raw_word(1'b1), 1'b0, NO_EVENT);
        send_word(midi_word(ST_CC, ch, n2, v2, 12'd0), 1'b0, NO_EVENT);
    endtask

    task automatic random_traffic(input int budget, input int gap_max);
        int         stop_at;
        int         pick;
        int         ch;
        logic [6:0] a;
        logic [6:0] b;
        logic [6:0] n;
        stop_at = words_sent + budget;
        while (words_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            ch = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
            a = $urandom_range(0, 127);
            b = $urandom_range(0, 127);
            n = a & 7'd31;
            if (pick < 14)
                send_pair(ch, CC_RPN_MSB, ($urandom_range(0, 5) == 0) ? a : 7'd0,
                          CC_RPN_LSB, $urandom_range(0, 6), gap_max);
            else if (pick < 20)
                send_pair(ch, CC_RPN_MSB, CC_VAL_MAX, CC_RPN_LSB,
                          ($urandom_range(0, 2) == 0) ? b : CC_VAL_MAX, gap_max);
            else if (pick < 32)
                send_pair(ch, CC_NRPN_MSB, a, CC_NRPN_LSB, b, gap_max);
            else if (pick < 50)
                send_pair(ch, CC_DATA_MSB, a, CC_DATA_LSB, b, gap_max);
            else if (pick < 60)
                send_pair(ch, n, b, n + 7'd32, a, gap_max);
            else if (pick < 68)
                repeat ($urandom_range(1, 4)) send_word(raw_word(1'b1), 1'b0, NO_EVENT);
            else if (pick < 86)
                send_word(midi_word($urandom_range(8, 15), $urandom_range(0, 15), a, b,
                                    $urandom_range(0, 4095)), 1'b0, NO_EVENT);
            else
                send_word(raw_word(1'b0), 1'b0, NO_EVENT);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // receiver side: random stall bursts, quiet stretches and one long hold-off
    initial begin : rx_side
        int stall_left;
        int quiet_left;
        int hold_left;
        bit hold_done;
        stall_left = 0;
        quiet_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && words_in >= 520) begin
                hold_left = 200;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (calm || quiet_left > 0) begin
                if (quiet_left > 0) quiet_left--;
                i_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                case ($urandom_range(0, 15))
                    0, 1, 2: stall_left = $urandom_range(1, 13);
                    3: quiet_left = $urandom_range(20, 60);
                    default: ;
                endcase
            end
        end
    end

    initial begin : stimulus
        logic [9:0]  mask;
        logic [19:0] win;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default filter: everything but sysex and clock, window 4800
        script.insert(script.size(), '{midi_word(ST_NOTEON, 0, 0, 0, 0), 1'b1,
                           event_of(KIND_NOTEON, 0, 0, 0)});
        script.insert(script.size(), '{midi_word(ST_NOTEOFF, 15, 127, 127, 0), 1'b1,
                           event_of(KIND_NOTEOFF, 15, 127, 127)});
        script.insert(script.size(), '{midi_word(ST_KEYPRESS, 5, 127, 0, 0), 1'b1,
                           event_of(KIND_KEYPRESS, 5, 127, 0)});
        script.insert(script.size(), '{midi_word(ST_PROG, 3, 127, 127, 0), 1'b1,
                           event_of(KIND_PROG, 3, 127, 0)});
        script.insert(script.size(), '{midi_word(ST_CHANPRESS, 9, 127, 127, 0), 1'b1,
                           event_of(KIND_CHANPRESS, 9, 0, 127)});
        script.insert(script.size(), '{midi_word(ST_PITCH, 1, 127, 127, 0), 1'b1,
                           event_of(KIND_PITCH, 1, 0, 16383)});
        script.insert(script.size(), '{midi_word(ST_SYSTEM, SYS_SONGPTR, 127, 127, 0), 1'b1,
                           event_of(KIND_SONGPTR, 0, 0, 16383)});
        script.insert(script.size(), '{midi_word(ST_SYSTEM, SYS_SONGSEL, 127, 0, 0), 1'b1,
                           event_of(KIND_SONGSEL, 0, 0, 127)});
        script.insert(script.size(), '{midi_word(ST_SYSTEM, SYS_START, 0, 0, 0), 1'b1,
                           event_of(KIND_START, 0, 0, 0)});
        script.insert(script.size(), '{midi_word(ST_SYSTEM, SYS_CONT, 0, 0, 0), 1'b1,
                           event_of(KIND_CONT, 0, 0, 0)});
        script.insert(script.size(), '{midi_word(ST_SYSTEM, SYS_STOP, 0, 0, 0), 1'b1,
                           event_of(KIND_STOP, 0, 0, 0)});
        script.insert(script.size(),
                      '{midi_word(ST_SYSTEM, SYS_SYSEX, 0, 0, 4095), 1'b0, NO_EVENT});
        script.insert(script.size(),
                      '{midi_word(ST_SYSTEM, SYS_CLOCK, 0, 0, 0), 1'b0, NO_EVENT});
        script.insert(script.size(),
                      '{midi_word(ST_NOTEOFF - 4'd1, 0, 127, 127, 0), 1'b0, NO_EVENT});
        script.insert(script.size(),
                      '{midi_word(ST_SYSTEM, SYS_SYSEX + 4'd1, 0, 0, 0), 1'b0, NO_EVENT});
        script.insert(script.size(), '{raw_word(1'b1), 1'b0, NO_EVENT});
        // rpn select, data entry, reset, nrpn select and fallback data entry
        script.insert(script.size(), '{midi_word(ST_CC, 2, CC_RPN_MSB, 0, 0), 1'b0, NO_EVENT});
        script.insert(script.size(), '{midi_word(ST_CC, 2, CC_RPN_LSB, 2, 0), 1'b0, NO_EVENT});
        script.insert(script.size(),
                      '{midi_word(ST_CC, 2, CC_DATA_MSB, 127, 0), 1'b0, NO_EVENT});
        script.insert(script.size(),
                      '{midi_word(ST_CC, 2, CC_DATA_LSB, 127, 0), 1'b0, NO_EVENT});
        script.insert(script.size(),
                      '{midi_word(ST_CC, 2, CC_RPN_MSB, 127, 0), 1'b0, NO_EVENT});
        script.insert(script.size(),
                      '{midi_word(ST_CC, 2, CC_RPN_LSB, 127, 0), 1'b0, NO_EVENT});
        script.insert(script.size(),
                      '{midi_word(ST_CC, 2, CC_NRPN_MSB, 127, 0), 1'b0, NO_EVENT});
        script.insert(script.size(),
                      '{midi_word(ST_CC, 2, CC_NRPN_LSB, 127, 0), 1'b0, NO_EVENT});
        script.insert(script.size(), '{midi_word(ST_CC, 2, CC_DATA_MSB, 0, 0), 1'b0, NO_EVENT});
        script.insert(script.size(), '{midi_word(ST_CC, 2, CC_DATA_LSB, 0, 0), 1'b0, NO_EVENT});
        // out-of-range rpn select, then a 14-bit cc with nothing selected
        script.insert(script.size(), '{midi_word(ST_CC, 4, CC_RPN_MSB, 0, 0), 1'b0, NO_EVENT});
        script.insert(script.size(), '{midi_word(ST_CC, 4, CC_RPN_LSB, 5, 0), 1'b0, NO_EVENT});
        script.insert(script.size(), '{midi_word(ST_CC, 4, CC_DATA_MSB, 1, 0), 1'b0, NO_EVENT});
        script.insert(script.size(), '{midi_word(ST_CC, 4, CC_DATA_LSB, 1, 0), 1'b0, NO_EVENT});

        foreach (script[i]) send_word(script[i].w, script[i].typed, script[i].res);

        for (int p = 0; p < 8; p++) begin
            wait_idle();
            case (p)
                0: begin mask = 10'h3FF; win = 20'd1; end
                1: begin mask = 10'h3FF; win = 20'hFFFFF; end
                2: begin mask = 10'h000; win = 20'd5; end
                3: begin mask = $urandom_range(0, 1023); win = $urandom_range(1, 16); end
                4: begin mask = 10'h3F7; win = 20'd8; end
                5: begin mask = 10'h3FF; win = 20'd6; end
                6: begin
                    mask = $urandom_range(0, 1023) | 10'h00C;
                    win = $urandom_range(1, 1048575);
                end
                default: begin mask = 10'h3FF; win = 20'd12; end
            endcase
            write_reg(CFG_SHOW_MASK, {10'd0, mask});
            write_reg(CFG_PAIR_WINDOW, win);
            calm = (p == 7);
            random_traffic(115, (win < 20'd40) ? int'(win) + 1 : 3);
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("[midi_event_classifier_rpn_decoder] OK");
        else
            $display("[midi_event_classifier_rpn_decoder] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
src/mecr_pkg.sv
src/mecr_front.sv
src/mecr_queue.sv
src/mecr_back.sv
src/midi_event_classifier_rpn_decoder.sv
tb/tb_top.sv
